// File: rtl/xtsd_pkg.sv
// shared types, tables and round functions for the xts sector decryptor
package xtsd_pkg;

    localparam int MAX_SECTOR_BLOCKS = 4096;
    localparam int LEN_W = $clog2(MAX_SECTOR_BLOCKS + 1);
    localparam int DONE_W = (MAX_SECTOR_BLOCKS > 1) ? $clog2(MAX_SECTOR_BLOCKS) : 1;
    localparam int ROUNDS = 10;

    localparam logic [2:0] REG_DATA_KEY_LO  = 3'd0;
    localparam logic [2:0] REG_DATA_KEY_HI  = 3'd1;
    localparam logic [2:0] REG_TWEAK_KEY_LO = 3'd2;
    localparam logic [2:0] REG_TWEAK_KEY_HI = 3'd3;
    localparam logic [2:0] REG_SECTOR_BLKS  = 3'd4;

    localparam logic [12:0] SECTOR_BLKS_RESET = 13'd1024;
    localparam logic [7:0] GF_POLY = 8'h87;
    localparam logic [7:0] AES_POLY = 8'h1b;

    typedef struct packed {
        logic [127:0] cipher;
        logic [63:0]  sector;
        logic         first;
        logic         last;
    } qent_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? AES_POLY : 8'h00);
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] idx);
        logic [7:0] r;
        r = 8'h00;
        unique case (idx)
            4'd1:  r = 8'h01;
            4'd2:  r = 8'h02;
            4'd3:  r = 8'h04;
            4'd4:  r = 8'h08;
            4'd5:  r = 8'h10;
            4'd6:  r = 8'h20;
            4'd7:  r = 8'h40;
            4'd8:  r = 8'h80;
            4'd9:  r = 8'h1b;
            4'd10: r = 8'h36;
            default: r = 8'h00;
        endcase
        rcon = r;
    endfunction

    // next round key from the previous one; byte i sits in bits 8i+7:8i
    function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] t;
        logic [31:0] n0, n1, n2, n3;
        t = {SBOX[k[103:96]], SBOX[k[127:120]], SBOX[k[119:112]],
             SBOX[k[111:104]] ^ rc};
        n0 = k[31:0] ^ t;
        n1 = k[63:32] ^ n0;
        n2 = k[95:64] ^ n1;
        n3 = k[127:96] ^ n2;
        key_step = {n3, n2, n1, n0};
    endfunction

    function automatic logic [127:0] enc_round(input logic [127:0] s, input logic [127:0] rk,
                                               input logic final_rnd);
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3;
        logic [127:0] o;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                t[r + 4 * c] = SBOX[s[8 * (r + 4 * ((c + r) & 3)) +: 8]];
        for (int c = 0; c < 4; c++)
        begin
            a0 = t[4 * c];
            a1 = t[4 * c + 1];
            a2 = t[4 * c + 2];
            a3 = t[4 * c + 3];
            if (final_rnd)
                o[32 * c +: 32] = {a3, a2, a1, a0};
            else
            begin
                o[32 * c +: 8]      = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
                o[32 * c + 8 +: 8]  = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
                o[32 * c + 16 +: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
                o[32 * c + 24 +: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
            end
        end
        enc_round = o ^ rk;
    endfunction

    function automatic logic [7:0] inv_mix_byte(input logic [7:0] b0, input logic [7:0] b1,
                                                input logic [7:0] b2, input logic [7:0] b3);
        // b0*14 ^ b1*11 ^ b2*13 ^ b3*9
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        x2[0] = xtime(b0); x4[0] = xtime(x2[0]); x8[0] = xtime(x4[0]);
        x2[1] = xtime(b1); x4[1] = xtime(x2[1]); x8[1] = xtime(x4[1]);
        x2[2] = xtime(b2); x4[2] = xtime(x2[2]); x8[2] = xtime(x4[2]);
        x2[3] = xtime(b3); x4[3] = xtime(x2[3]); x8[3] = xtime(x4[3]);
        inv_mix_byte = (x8[0] ^ x4[0] ^ x2[0]) ^ (x8[1] ^ x2[1] ^ b1)
                     ^ (x8[2] ^ x4[2] ^ b2) ^ (x8[3] ^ b3);
    endfunction

    function automatic logic [127:0] dec_round(input logic [127:0] s, input logic [127:0] rk,
                                               input logic do_mix);
        logic [127:0] t;
        logic [7:0] a0, a1, a2, a3;
        logic [127:0] o;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                t[8 * (r + 4 * ((c + r) & 3)) +: 8] = INV_SBOX[s[8 * (r + 4 * c) +: 8]];
        t = t ^ rk;
        o = t;
        if (do_mix)
        begin
            for (int c = 0; c < 4; c++)
            begin
                a0 = t[32 * c +: 8];
                a1 = t[32 * c + 8 +: 8];
                a2 = t[32 * c + 16 +: 8];
                a3 = t[32 * c + 24 +: 8];
                o[32 * c +: 8]      = inv_mix_byte(a0, a1, a2, a3);
                o[32 * c + 8 +: 8]  = inv_mix_byte(a1, a2, a3, a0);
                o[32 * c + 16 +: 8] = inv_mix_byte(a2, a3, a0, a1);
                o[32 * c + 24 +: 8] = inv_mix_byte(a3, a0, a1, a2);
            end
        end
        dec_round = o;
    endfunction

    // multiply by x in GF(2^128), little-endian byte order
    function automatic logic [127:0] gf_double(input logic [127:0] t);
        gf_double = {t[126:0], 1'b0} ^ {120'd0, (t[127] ? GF_POLY : 8'h00)};
    endfunction

    function automatic logic [63:0] byte_swap64(input logic [63:0] v);
        logic [63:0] o;
        for (int i = 0; i < 8; i++)
            o[8 * i +: 8] = v[8 * (7 - i) +: 8];
        byte_swap64 = o;
    endfunction

endpackage

// File: rtl/xts_aes128_sector_decrypt_top.sv
// top level of the xts-aes-128 sector decryptor
// usage
//   s_axis carries one 16-byte ciphertext block per transfer plus the sector
//   number, which is only looked at on the first block of a sector. m_axis
//   returns the plaintext block; tlast marks the block that ends the sector.
//   the cfg port writes the data key, the tweak key and the sector length.
// round unit and queue
//   a block passes through the shared aes round unit as key whitening plus
//   ten rounds, one round per cycle; on the first block of a sector the tweak
//   is encrypted in the same unit first. a two-entry queue sits between the
//   input side and the round unit, so the next blocks are taken while one is
//   being decrypted.
// key writes
//   a write to either half of a key runs the key schedule, one round key
//   per cycle; s_axis_tready is held low meanwhile.
// reset and stalls
//   reset clears the tweak, the sector position and the queue; keys read as
//   zero, sector length 1024 blocks, round keys need a key write. a result
//   waits in the output register while m_axis_tready is low; the queue keeps
//   filling until full, then s_axis_tready drops.
module xts_aes128_sector_decrypt_top
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [191:0] s_axis_tdata,   // cipher_low, cipher_high, sector_number
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // plain_low, plain_high
    output logic         m_axis_tlast,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_addr,
    input  logic [63:0]  cfg_wdata
);

    logic [12:0]      sector_blocks_reg;
    logic             dk_busy, tk_busy, key_busy;
    logic [3:0]       trk_idx, drk_idx;
    logic [127:0]     trk, drk;
    logic             q_valid, q_pop;
    xtsd_pkg::qent_t  q_data;

    // sector length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sector_blocks_reg <= xtsd_pkg::SECTOR_BLKS_RESET;
        else if (cfg_we && (cfg_addr == xtsd_pkg::REG_SECTOR_BLKS))
            sector_blocks_reg <= cfg_wdata[12:0];
    end

    // data key schedule
    xtsd_keyexp u_dkey
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_lo  (cfg_we && (cfg_addr == xtsd_pkg::REG_DATA_KEY_LO)),
        .wr_hi  (cfg_we && (cfg_addr == xtsd_pkg::REG_DATA_KEY_HI)),
        .wdata  (cfg_wdata),
        .rd_idx (drk_idx),
        .rd_key (drk),
        .busy   (dk_busy)
    );

    // tweak key schedule
    xtsd_keyexp u_tkey
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_lo  (cfg_we && (cfg_addr == xtsd_pkg::REG_TWEAK_KEY_LO)),
        .wr_hi  (cfg_we && (cfg_addr == xtsd_pkg::REG_TWEAK_KEY_HI)),
        .wdata  (cfg_wdata),
        .rd_idx (trk_idx),
        .rd_key (trk),
        .busy   (tk_busy)
    );

    assign key_busy = dk_busy || tk_busy;

    // input side: sector position and queue
    xtsd_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .in_data       (s_axis_tdata),
        .sector_blocks (sector_blocks_reg),
        .hold          (key_busy),
        .q_valid       (q_valid),
        .q_data        (q_data),
        .q_pop         (q_pop)
    );

    // round engine and output register
    xtsd_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .trk_idx   (trk_idx),
        .trk       (trk),
        .drk_idx   (drk_idx),
        .drk       (drk),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

`ifndef SYNTHESIS
    a_no_accept_during_keysched: assert property (@(posedge clk) disable iff (!rst_n)
        key_busy |-> !s_axis_tready)
        else $error("transfer accepted while key schedule runs");

    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_keysched_start_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(key_busy) |-> $past(cfg_we))
        else $error("key schedule started without a key write");
`endif

endmodule

// File: rtl/xtsd_keyexp.sv
// key register pair with an iterative aes-128 key schedule, one round key per cycle
module xtsd_keyexp
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_lo,
    input  logic         wr_hi,
    input  logic [63:0]  wdata,
    input  logic [3:0]   rd_idx,
    output logic [127:0] rd_key,
    output logic         busy
);

    logic [63:0]  key_lo_reg, key_hi_reg;
    logic         busy_reg;
    logic [3:0]   cnt_reg;
    logic [127:0] cur_reg;
    logic [127:0] rk_reg [11];
    logic [127:0] new_key;
    logic [127:0] nxt_key;

    assign new_key = wr_lo ? {key_hi_reg, wdata} : {wdata, key_lo_reg};
    assign nxt_key = xtsd_pkg::key_step(cur_reg, xtsd_pkg::rcon(cnt_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_lo_reg <= '0;
            key_hi_reg <= '0;
            busy_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (wr_lo)
                key_lo_reg <= wdata;
            if (wr_hi)
                key_hi_reg <= wdata;
            if (wr_lo || wr_hi)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 4'd1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'(xtsd_pkg::ROUNDS))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_lo || wr_hi)
        begin
            cur_reg   <= new_key;
            rk_reg[0] <= new_key;
        end
        else if (busy_reg)
        begin
            cur_reg         <= nxt_key;
            rk_reg[cnt_reg] <= nxt_key;
        end
    end

    assign rd_key = rk_reg[rd_idx];
    assign busy   = busy_reg;

endmodule

// File: rtl/xtsd_front.sv
// input side: sector position tracking and a two-entry queue toward the cipher core
module xtsd_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [191:0]          in_data,
    input  logic [12:0]           sector_blocks,
    input  logic                  hold,
    output logic                  q_valid,
    output xtsd_pkg::qent_t       q_data,
    input  logic                  q_pop
);

    xtsd_pkg::qent_t q_reg [2];
    logic [1:0]  cnt_reg;
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [xtsd_pkg::DONE_W-1:0] done_reg;
    logic [xtsd_pkg::LEN_W-1:0]  len;
    logic [xtsd_pkg::LEN_W-1:0]  done_inc;
    logic        last;
    logic        push;
    xtsd_pkg::qent_t ent;

    always_comb
    begin
        if (sector_blocks == 13'd0)
            len = xtsd_pkg::LEN_W'(1);
        else if ({{(32-13){1'b0}}, sector_blocks} > 32'(xtsd_pkg::MAX_SECTOR_BLOCKS))
            len = xtsd_pkg::LEN_W'(xtsd_pkg::MAX_SECTOR_BLOCKS);
        else
            len = xtsd_pkg::LEN_W'(sector_blocks);
    end

    assign done_inc = xtsd_pkg::LEN_W'(done_reg) + xtsd_pkg::LEN_W'(1);
    assign last     = done_inc >= len;
    assign in_ready = (cnt_reg != 2'd2) && !hold;
    assign push     = in_valid && in_ready;

    assign ent.cipher = in_data[127:0];
    assign ent.sector = in_data[191:128];
    assign ent.first  = (done_reg == '0);
    assign ent.last   = last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            done_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
                done_reg   <= last ? '0 : xtsd_pkg::DONE_W'(done_inc);
            end
            if (q_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !q_pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (!push && q_pop)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= ent;
    end

    assign q_valid = (cnt_reg != 2'd0);
    assign q_data  = q_reg[rd_ptr_reg];

endmodule

// File: rtl/xtsd_core.sv
// iterative aes round engine: tweak encryption, block decryption and the output register
module xtsd_core
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  xtsd_pkg::qent_t       q_data,
    output logic                  q_pop,
    output logic [3:0]            trk_idx,
    input  logic [127:0]          trk,
    output logic [3:0]            drk_idx,
    input  logic [127:0]          drk,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [127:0]          out_data,
    output logic                  out_last
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_TWK  = 2'd1;
    localparam logic [1:0] ST_DEC  = 2'd2;

    logic [1:0]   state_reg;
    logic [3:0]   rnd_reg;
    logic [127:0] st_reg;
    logic [127:0] tweak_reg;
    logic [127:0] cblk_reg;
    logic         last_reg;
    logic         ov_reg;
    logic [127:0] od_reg;
    logic         ol_reg;
    logic [127:0] enc_out, dec_out;
    logic         out_free;
    logic         finish;
    logic [127:0] tw0;

    assign enc_out  = xtsd_pkg::enc_round(st_reg, trk, rnd_reg == 4'(xtsd_pkg::ROUNDS));
    assign dec_out  = xtsd_pkg::dec_round(st_reg, drk, rnd_reg != 4'd0);
    assign out_free = !ov_reg || out_ready;
    assign finish   = (state_reg == ST_DEC) && (rnd_reg == 4'd0) && out_free;
    assign q_pop    = (state_reg == ST_IDLE) && q_valid;
    assign tw0      = {xtsd_pkg::byte_swap64(q_data.sector), 64'd0};

    always_comb
    begin
        trk_idx = 4'd0;
        drk_idx = 4'(xtsd_pkg::ROUNDS);
        unique case (state_reg)
            ST_IDLE: trk_idx = 4'd0;
            ST_TWK:  trk_idx = rnd_reg;
            ST_DEC:  drk_idx = rnd_reg;
            default: trk_idx = 4'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rnd_reg   <= '0;
            ov_reg    <= 1'b0;
            tweak_reg <= '0;
        end
        else
        begin
            if (finish)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        if (q_data.first)
                        begin
                            state_reg <= ST_TWK;
                            rnd_reg   <= 4'd1;
                        end
                        else
                        begin
                            state_reg <= ST_DEC;
                            rnd_reg   <= 4'(xtsd_pkg::ROUNDS - 1);
                        end
                    end
                end
                ST_TWK:
                begin
                    if (rnd_reg == 4'(xtsd_pkg::ROUNDS))
                    begin
                        tweak_reg <= enc_out;
                        state_reg <= ST_DEC;
                        rnd_reg   <= 4'(xtsd_pkg::ROUNDS - 1);
                    end
                    else
                        rnd_reg <= rnd_reg + 4'd1;
                end
                ST_DEC:
                begin
                    if (rnd_reg != 4'd0)
                        rnd_reg <= rnd_reg - 4'd1;
                    else if (out_free)
                    begin
                        tweak_reg <= xtsd_pkg::gf_double(tweak_reg);
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cblk_reg <= q_data.cipher;
            last_reg <= q_data.last;
            if (q_data.first)
                st_reg <= tw0 ^ trk;
            else
                st_reg <= q_data.cipher ^ tweak_reg ^ drk;
        end
        else if (state_reg == ST_TWK)
        begin
            if (rnd_reg == 4'(xtsd_pkg::ROUNDS))
                st_reg <= cblk_reg ^ enc_out ^ drk;
            else
                st_reg <= enc_out;
        end
        else if ((state_reg == ST_DEC) && (rnd_reg != 4'd0))
            st_reg <= dec_out;
        if (finish)
        begin
            od_reg <= dec_out ^ tweak_reg;
            ol_reg <= last_reg;
        end
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;
    assign out_last  = ol_reg;

endmodule
